// File: sv/ic_pkg.sv
// Shared types and constants for the inversion counter.
`default_nettype none

package ic_pkg;

   // Default sizing
   localparam int DEF_MAX_ITEMS  = 1024;
   localparam int DEF_VALUE_BITS = 32;

   // Width of the reported total; the running total saturates at all ones
   localparam int TOTAL_BITS = 19;

   // Control bits of a word travelling down the cell chain
   typedef struct packed {
      logic valid;   // slot holds a word
      logic last;    // word closes the sequence
      logic drop;    // word arrived with the store full
   } ctl_type;

endpackage

`default_nettype wire

// File: sv/ic_front.sv
// Input stage: numbers each word of a sequence and maps its value to an ordered key.
`default_nettype none

module ic_front #(
   parameter int MAX_ITEMS  = ic_pkg::DEF_MAX_ITEMS,
   parameter int VALUE_BITS = ic_pkg::DEF_VALUE_BITS,
   parameter int IDX_W      = $clog2(MAX_ITEMS + 1),
   parameter int CNT_W      = $clog2(MAX_ITEMS)
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         advance,
   input  wire                         req_valid,
   input  wire signed [VALUE_BITS-1:0] req_value,
   input  wire                         req_last,
   output ic_pkg::ctl_type             dn_ctl,
   output logic [IDX_W-1:0]            dn_idx,
   output logic [VALUE_BITS-1:0]       dn_key,
   output logic [CNT_W-1:0]            dn_cnt
);

   localparam logic [IDX_W-1:0] FULL = IDX_W'(MAX_ITEMS);

   logic [IDX_W-1:0] count_ff;
   logic [IDX_W-1:0] count_in;
   logic             accept;
   logic             full;

   always_comb begin
      accept = req_valid && advance;
      full   = (count_ff == FULL);

      dn_ctl.valid = accept;
      dn_ctl.last  = req_last;
      dn_ctl.drop  = full;
      dn_idx       = count_ff;
      // flip the sign bit so an unsigned compare orders two's complement values
      dn_key       = {~req_value[VALUE_BITS-1], req_value[VALUE_BITS-2:0]};
      dn_cnt       = '0;

      count_in = count_ff;
      if (accept) begin
         if (req_last) begin
            count_in = '0;
         end else if (!full) begin
            count_in = count_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/ic_cell.sv
// One chain cell: holds one stored key and counts passing words smaller than it.
`default_nettype none

module ic_cell #(
   parameter int INDEX      = 0,
   parameter int VALUE_BITS = ic_pkg::DEF_VALUE_BITS,
   parameter int IDX_W      = 11,
   parameter int CNT_W      = 10
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   advance,
   input  ic_pkg::ctl_type       up_ctl,
   input  wire [IDX_W-1:0]       up_idx,
   input  wire [VALUE_BITS-1:0]  up_key,
   input  wire [CNT_W-1:0]       up_cnt,
   output ic_pkg::ctl_type       dn_ctl,
   output logic [IDX_W-1:0]      dn_idx,
   output logic [VALUE_BITS-1:0] dn_key,
   output logic [CNT_W-1:0]      dn_cnt
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   ic_pkg::ctl_type       ctl_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [VALUE_BITS-1:0] key_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      cnt_in;
   logic [VALUE_BITS-1:0] held_ff;
   logic                  live;
   logic                  hit;
   logic                  store;

   always_comb begin
      live  = up_ctl.valid && !up_ctl.drop;
      // only a slot filled earlier in this sequence takes part
      hit   = live && (up_idx > MY_IDX) && (held_ff > up_key);
      store = live && (up_idx == MY_IDX);
      cnt_in = up_cnt + CNT_W'(hit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         idx_ff <= up_idx;
         key_ff <= up_key;
         cnt_ff <= cnt_in;
      end
      if (advance && store) begin
         held_ff <= up_key;
      end
   end

   assign dn_ctl = ctl_ff;
   assign dn_idx = idx_ff;
   assign dn_key = key_ff;
   assign dn_cnt = cnt_ff;

endmodule

`default_nettype wire

// File: sv/ic_tail.sv
// Chain end: accumulates the saturating total and overflow, drives the result word.
`default_nettype none

module ic_tail #(
   parameter int CNT_W = 10
) (
   input  wire                               clock,
   input  wire                               reset,
   input  ic_pkg::ctl_type                   up_ctl,
   input  wire [CNT_W-1:0]                   up_cnt,
   output logic                              advance,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [ic_pkg::TOTAL_BITS-1:0]     rsp_inversions,
   output logic                              rsp_overflowed
);

   localparam int TB    = ic_pkg::TOTAL_BITS;
   localparam int SUM_W = ((CNT_W > TB) ? CNT_W : TB) + 1;
   localparam logic [SUM_W-1:0] SAT = SUM_W'({TB{1'b1}});

   logic [TB-1:0]    total_ff;
   logic [TB-1:0]    total_in;
   logic             ovf_ff;
   logic             ovf_in;
   logic             out_valid_ff;
   logic             out_valid_in;
   logic [TB-1:0]    out_total_ff;
   logic             out_ovf_ff;
   logic [SUM_W-1:0] sum;
   logic [TB-1:0]    new_total;
   logic             new_ovf;
   logic             take;
   logic             emit;

   always_comb begin
      // hold the chain only when a closing word meets a full, stalled output
      advance = !(out_valid_ff && rsp_stall && up_ctl.valid && up_ctl.last);
      take    = advance && up_ctl.valid;
      emit    = take && up_ctl.last;

      sum = SUM_W'(total_ff) + SUM_W'(up_cnt);
      if (up_ctl.valid && !up_ctl.drop) begin
         new_total = (sum > SAT) ? SAT[TB-1:0] : sum[TB-1:0];
      end else begin
         new_total = total_ff;
      end
      new_ovf = ovf_ff || (up_ctl.valid && up_ctl.drop);

      total_in = total_ff;
      ovf_in   = ovf_ff;
      if (take) begin
         total_in = up_ctl.last ? '0 : new_total;
         ovf_in   = up_ctl.last ? 1'b0 : new_ovf;
      end

      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_total_ff <= new_total;
         out_ovf_ff   <= new_ovf;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_inversions = out_total_ff;
   assign rsp_overflowed = out_ovf_ff;

endmodule

`default_nettype wire

// File: sv/inversion_counter_top.sv
// Inversion counter: systolic chain of compare cells with an accumulating tail.
// Throughput: one word per cycle; a new word is taken every cycle unless the
//   closing word of a sequence waits on a full, stalled result register.
// Result path: the closing word walks the chain of MAX_ITEMS cells, then the tail
//   registers the result word.
// Reset: synchronous; clears the slot valids, item count, total and overflow.
//   Stored keys need no clearing, so words are accepted right after reset.
`default_nettype none

module inversion_counter_top #(
   parameter int MAX_ITEMS  = ic_pkg::DEF_MAX_ITEMS,
   parameter int VALUE_BITS = ic_pkg::DEF_VALUE_BITS
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire signed [VALUE_BITS-1:0]       req_value,
   input  wire                               req_last,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [ic_pkg::TOTAL_BITS-1:0]     rsp_inversions,
   output logic                              rsp_overflowed
);

   localparam int IDX_W = $clog2(MAX_ITEMS + 1);
   localparam int CNT_W = $clog2(MAX_ITEMS);

   // link g feeds cell g; link MAX_ITEMS feeds the tail
   ic_pkg::ctl_type       link_ctl [MAX_ITEMS+1];
   logic [IDX_W-1:0]      link_idx [MAX_ITEMS+1];
   logic [VALUE_BITS-1:0] link_key [MAX_ITEMS+1];
   logic [CNT_W-1:0]      link_cnt [MAX_ITEMS+1];
   logic                  advance;

   ic_front #(
      .MAX_ITEMS  (MAX_ITEMS),
      .VALUE_BITS (VALUE_BITS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_valid (req_valid),
      .req_value (req_value),
      .req_last  (req_last),
      .dn_ctl    (link_ctl[0]),
      .dn_idx    (link_idx[0]),
      .dn_key    (link_key[0]),
      .dn_cnt    (link_cnt[0])
   );

   for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
      ic_cell #(
         .INDEX      (g),
         .VALUE_BITS (VALUE_BITS),
         .IDX_W      (IDX_W),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up_ctl  (link_ctl[g]),
         .up_idx  (link_idx[g]),
         .up_key  (link_key[g]),
         .up_cnt  (link_cnt[g]),
         .dn_ctl  (link_ctl[g+1]),
         .dn_idx  (link_idx[g+1]),
         .dn_key  (link_key[g+1]),
         .dn_cnt  (link_cnt[g+1])
      );
   end

   ic_tail #(
      .CNT_W (CNT_W)
   ) u_tail (
      .clock          (clock),
      .reset          (reset),
      .up_ctl         (link_ctl[MAX_ITEMS]),
      .up_cnt         (link_cnt[MAX_ITEMS]),
      .advance        (advance),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_inversions (rsp_inversions),
      .rsp_overflowed (rsp_overflowed)
   );

   assign req_stall = !advance;

endmodule

`default_nettype wire

// File: tb/tb_inversion_counter_top.sv
// Self-checking testbench for inversion_counter_top: random sequences against a scoreboard.
`timescale 1ns / 100ps

class inversion_scoreboard;
   localparam int DEPTH = ic_pkg::DEF_MAX_ITEMS;
   localparam int VBITS = ic_pkg::DEF_VALUE_BITS;
   localparam int TBITS = ic_pkg::TOTAL_BITS;
   localparam int RBITS = TBITS + 1;
   localparam logic [TBITS:0] TOTAL_CAP = {1'b0, {TBITS{1'b1}}};

   logic signed [VBITS-1:0] held_words[DEPTH];
   int unsigned held_count;
   logic [TBITS:0] run_total;
   logic dropped_any;
   logic [TBITS-1:0] due_inversions[$];
   logic due_overflow[$];
   int mismatches;
   int totals_queued;

   function new();
      held_count = 0;
      run_total = '0;
      dropped_any = 1'b0;
      mismatches = 0;
      totals_queued = 0;
   endfunction

   // Fold one accepted word into the running count; queue a total on the closing word.
   function void note_word(logic signed [VBITS-1:0] word, logic is_last);
      int unsigned greater;
      greater = 0;
      if (held_count < DEPTH) begin
         for (int i = 0; i < held_count; i++) begin
            if (held_words[i] > word) greater++;
         end
         if (greater > TOTAL_CAP - run_total)
            run_total = TOTAL_CAP;
         else
            run_total = run_total + RBITS'(greater);
         held_words[held_count] = word;
         held_count++;
      end else begin
         // store full: drop the word, remember it
         dropped_any = 1'b1;
      end
      if (is_last) begin
         due_inversions.push_back(run_total[TBITS-1:0]);
         due_overflow.push_back(dropped_any);
         totals_queued++;
         held_count = 0;
         run_total = '0;
         dropped_any = 1'b0;
      end
   endfunction

   function void check_total(logic [TBITS-1:0] got_inversions, logic got_overflow);
      logic [TBITS-1:0] want_inversions;
      logic want_overflow;
      if (due_inversions.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: total %0d overflow %0b arrived with nothing expected",
                     got_inversions, got_overflow);
         return;
      end
      want_inversions = due_inversions.pop_front();
      want_overflow = due_overflow.pop_front();
      if (got_inversions !== want_inversions || got_overflow !== want_overflow) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: inversions expected %0d got %0d, overflow expected %0b got %0b",
                     want_inversions, got_inversions, want_overflow, got_overflow);
      end
   endfunction

   function int waiting();
      return due_inversions.size();
   endfunction
endclass

module tb_inversion_counter_top;
   localparam int MAX_ITEMS = ic_pkg::DEF_MAX_ITEMS;
   localparam int VALUE_BITS = ic_pkg::DEF_VALUE_BITS;
   localparam int WORD_GOAL = 1450;

   typedef enum int {
      STYLE_WIDE,
      STYLE_TIES,
      STYLE_EDGES,
      STYLE_FALLING,
      STYLE_RISING
   } value_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [VALUE_BITS-1:0] req_value = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ic_pkg::TOTAL_BITS-1:0] rsp_inversions;
   logic rsp_overflowed;

   inversion_scoreboard board;
   bit tx_idle = 1'b0;
   bit rx_idle = 1'b0;
   int words_sent = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   inversion_counter_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_inversions(rsp_inversions),
      .rsp_overflowed(rsp_overflowed)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_total(rsp_inversions, rsp_overflowed);
   end

   // Result side: hold stall for a random count per total, then wait for the handshake.
   initial begin
      int hold;
      wait (!reset);
      forever begin
         hold = rx_idle ? $urandom_range(0, 7) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_word(input logic signed [VALUE_BITS-1:0] word, input logic is_last);
      int gap;
      gap = tx_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= word;
      req_last <= is_last;
      do @(posedge clock); while (req_stall);
      board.note_word(word, is_last);
      words_sent++;
   endtask

   function automatic logic signed [VALUE_BITS-1:0] pick_value(value_style_type style, int idx);
      case (style)
         STYLE_WIDE: return $urandom;
         STYLE_TIES: return int'($urandom_range(0, 16)) - 8;
         STYLE_EDGES: begin
            case ($urandom_range(0, 5))
               0: return {1'b1, {(VALUE_BITS-1){1'b0}}};
               1: return {1'b0, {(VALUE_BITS-1){1'b1}}};
               2: return '0;
               3: return '1;
               4: return 1;
               default: return $urandom;
            endcase
         end
         STYLE_FALLING: return 100000 - idx;
         default: return idx + int'($urandom_range(0, 3));
      endcase
   endfunction

   task automatic send_sequence(input int len, input value_style_type style);
      for (int i = 0; i < len; i++)
         send_word(pick_value(style, i), i == len - 1);
   endtask

   // Stop feeding words until every queued total is back.
   task automatic drain_totals();
      req_valid <= 1'b0;
      while (board.waiting() != 0) @(posedge clock);
   endtask

   initial begin
      int len;
      int round;
      value_style_type style;
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // single word, sign extremes both ways, ties, falling run across zero, bit patterns
      send_word(0, 1'b1);
      send_word({1'b0, {(VALUE_BITS-1){1'b1}}}, 1'b0);
      send_word({1'b1, {(VALUE_BITS-1){1'b0}}}, 1'b1);
      send_word({1'b1, {(VALUE_BITS-1){1'b0}}}, 1'b0);
      send_word({1'b0, {(VALUE_BITS-1){1'b1}}}, 1'b1);
      send_word(5, 1'b0);
      send_word(5, 1'b0);
      send_word(5, 1'b1);
      for (int v = 3; v >= -2; v--)
         send_word(v, v == -2);
      send_word(32'hAAAA_AAAA, 1'b0);
      send_word(32'h5555_5555, 1'b0);
      send_word(-1, 1'b0);
      send_word(0, 1'b1);

      round = 0;
      while (words_sent < WORD_GOAL || round < 13) begin
         tx_idle = $urandom_range(0, 3) != 0;
         rx_idle = $urandom_range(0, 3) != 0;
         round++;
         if (round == 12) begin
            // overrun the store with a falling run: largest total, then dropped words;
            // the closing word itself is dropped
            send_sequence(MAX_ITEMS + 2, STYLE_FALLING);
            drain_totals();
         end else begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(21, 64) : $urandom_range(1, 20);
            style = value_style_type'($urandom_range(0, 4));
            send_sequence(len, style);
         end
      end

      req_valid <= 1'b0;
      while (board.waiting() != 0) @(posedge clock);
      repeat (MAX_ITEMS + 64) @(posedge clock);
      if (board.mismatches == 0 && board.waiting() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
